// File: rtl/smon_pkg.sv
package smon_pkg;

  localparam int NUM_STATES_DEF = 16;

  localparam int PID_W   = 22;
  localparam int CALL_W  = 10;
  localparam int INDEX_W = 10;
  localparam int ENTRY_W = 13;
  localparam int STATE_W = 5;
  localparam int VERD_W  = 2;

  localparam logic signed [ENTRY_W-1:0] EPSILON_EDGE = -13'sd1;
  localparam logic [CALL_W-1:0]         CLOSE_CALL   = 10'd3;

  localparam logic [VERD_W-1:0] VERDICT_ALLOW = 2'd0;
  localparam logic [VERD_W-1:0] VERDICT_DEAD  = 2'd1;
  localparam logic [VERD_W-1:0] VERDICT_KILL  = 2'd2;

  localparam logic [0:0] CFG_WATCHED_PID = 1'b0;
  localparam logic [0:0] CFG_DEAD_STATE  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OUT_RD,
    ST_OUT_CMP,
    ST_IN_RD,
    ST_IN_CMP,
    ST_FINISH
  } fsm_t;

  typedef struct packed {
    logic hit;
    logic eps;
  } cmp_t;

endpackage

// File: rtl/smon_ram.sv
module smon_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/smon_cmp.sv
module smon_cmp (
  input  logic signed [smon_pkg::ENTRY_W-1:0] entry,
  input  logic        [smon_pkg::CALL_W-1:0]  call,
  output smon_pkg::cmp_t                      res
);

  import smon_pkg::*;

  // call is zero-extended; -1 and values above 1023 can never hit
  assign res.hit = (entry == $signed({3'b000, call}));
  assign res.eps = (entry == EPSILON_EDGE);

endmodule

// File: rtl/smon_ctrl.sv
module smon_ctrl #(
  parameter int NUM_STATES = smon_pkg::NUM_STATES_DEF,
  parameter int AW         = $clog2(NUM_STATES * NUM_STATES)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                action,
  input  logic        [smon_pkg::PID_W-1:0]   pid,
  input  logic        [smon_pkg::CALL_W-1:0]  syscall_id,
  input  logic        [smon_pkg::INDEX_W-1:0] entry_index,
  input  logic signed [smon_pkg::ENTRY_W-1:0] entry_value,
  input  logic        [smon_pkg::PID_W-1:0]   watched_pid,
  input  logic        [smon_pkg::STATE_W-1:0] dead_state,
  output logic                                ram_we,
  output logic        [AW-1:0]                ram_addr,
  output logic signed [smon_pkg::ENTRY_W-1:0] ram_wdata,
  input  logic signed [smon_pkg::ENTRY_W-1:0] ram_rdata,
  output logic                                result_valid,
  output logic        [smon_pkg::VERD_W-1:0]  verdict,
  output logic        [smon_pkg::STATE_W-1:0] new_state
);

  import smon_pkg::*;

  localparam int SW    = $clog2(NUM_STATES);
  localparam int TSIZE = NUM_STATES * NUM_STATES;

  fsm_t                fsm, fsm_next;
  logic [AW-1:0]       clr_cnt;
  logic [SW-1:0]       row, col_i, col_j, found_col;
  logic [CALL_W-1:0]   call_q;
  logic                found, possible_dead, dead_latched;
  logic [STATE_W-1:0]  cur_state;
  cmp_t                cmp;
  logic                accept, is_call, in_range, clr_last, i_last, j_last;

  smon_cmp u_cmp (
    .entry (ram_rdata),
    .call  (call_q),
    .res   (cmp)
  );

  assign accept   = start && (fsm == ST_IDLE);
  assign is_call  = accept && action && (pid == watched_pid);
  assign in_range = ({1'b0, entry_index} < (INDEX_W + 1)'(TSIZE));
  assign clr_last = (clr_cnt == AW'(TSIZE - 1));
  assign i_last   = (col_i == SW'(NUM_STATES - 1));
  assign j_last   = (col_j == SW'(NUM_STATES - 1));

  always_comb begin
    fsm_next = fsm;
    case (fsm)
      ST_CLEAR: begin
        if (clr_last) fsm_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (is_call) fsm_next = dead_latched ? ST_FINISH : ST_OUT_RD;
      end
      ST_OUT_RD: fsm_next = ST_OUT_CMP;
      ST_OUT_CMP: begin
        if (cmp.hit)     fsm_next = ST_FINISH;
        else if (cmp.eps) fsm_next = ST_IN_RD;
        else if (i_last) fsm_next = ST_FINISH;
        else             fsm_next = ST_OUT_RD;
      end
      ST_IN_RD: fsm_next = ST_IN_CMP;
      ST_IN_CMP: begin
        if (cmp.hit)      fsm_next = ST_FINISH;
        else if (!j_last) fsm_next = ST_IN_RD;
        else if (i_last)  fsm_next = ST_FINISH;
        else              fsm_next = ST_OUT_RD;
      end
      ST_FINISH: fsm_next = ST_IDLE;
      default:   fsm_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (fsm != ST_IDLE);
    ram_we    = 1'b0;
    ram_wdata = entry_value;
    ram_addr  = '0;
    case (fsm)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        ram_addr  = clr_cnt;
      end
      ST_IDLE: begin
        ram_we   = accept && !action && in_range;
        ram_addr = entry_index[AW-1:0];
      end
      ST_OUT_RD: ram_addr = AW'(row) * AW'(NUM_STATES) + AW'(col_i);
      ST_IN_RD:  ram_addr = AW'(col_i) * AW'(NUM_STATES) + AW'(col_j);
      default:   ram_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm          <= ST_CLEAR;
      clr_cnt      <= '0;
      cur_state    <= '0;
      dead_latched <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      fsm          <= fsm_next;
      result_valid <= 1'b0;
      if (fsm == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;

      if (is_call) begin
        call_q        <= syscall_id;
        row           <= cur_state[SW-1:0];
        col_i         <= '0;
        found         <= 1'b0;
        possible_dead <= 1'b0;
      end

      if (fsm == ST_OUT_CMP) begin
        if (cmp.hit) begin
          found     <= 1'b1;
          found_col <= col_i;
        end else if (cmp.eps) begin
          col_j <= '0;
          if (5'(col_i) == dead_state) possible_dead <= 1'b1;
        end else begin
          col_i <= col_i + 1'b1;
        end
      end

      if (fsm == ST_IN_CMP) begin
        if (cmp.hit) begin
          found     <= 1'b1;
          found_col <= col_j;
        end else if (j_last) begin
          col_i <= col_i + 1'b1;
        end else begin
          col_j <= col_j + 1'b1;
        end
      end

      if (fsm == ST_FINISH) begin
        result_valid <= 1'b1;
        if (found) begin
          verdict   <= VERDICT_ALLOW;
          new_state <= 5'(found_col);
          cur_state <= 5'(found_col);
        end else if (possible_dead && (call_q == CLOSE_CALL)) begin
          verdict      <= VERDICT_DEAD;
          new_state    <= dead_state;
          cur_state    <= dead_state;
          dead_latched <= 1'b1;
        end else begin
          verdict   <= VERDICT_KILL;
          new_state <= cur_state;
        end
      end
    end
  end

  a_finish_strobe: assert property (@(posedge clk) disable iff (rst)
    (fsm == ST_FINISH) |=> result_valid)
    else $error("finish did not raise result strobe");

  a_dead_latches: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (verdict == VERDICT_DEAD)) |-> dead_latched)
    else $error("dead verdict without latched flag");

  a_inner_order: assert property (@(posedge clk) disable iff (rst)
    (fsm == ST_IN_CMP) |-> ($past(fsm) == ST_IN_RD))
    else $error("inner compare without read");

  a_state_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ({1'b0, new_state} < 6'(NUM_STATES)))
    else $error("new_state outside table");

endmodule

// File: rtl/syscall_automaton_monitor.sv
// Timing: a table write or a call from another process is absorbed in its accept cycle.
// A watched call makes 1 .. N + N*N table reads (none once the dead flag is latched), each
// a read state then a compare state, and raises the result strobe after the finish state.
// Flow: one item at a time, busy high until the strobe cycle.
// Reset: synchronous; a clearing pass zeroes all N*N table entries, busy held high.
// Result strobe is one cycle wide, receiver cannot stall.
module syscall_automaton_monitor #(
  parameter int NUM_STATES = smon_pkg::NUM_STATES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // item transaction
  input  logic                                start,
  output logic                                busy,
  input  logic                                action,
  input  logic        [smon_pkg::PID_W-1:0]   pid,
  input  logic        [smon_pkg::CALL_W-1:0]  syscall_id,
  input  logic        [smon_pkg::INDEX_W-1:0] entry_index,
  input  logic signed [smon_pkg::ENTRY_W-1:0] entry_value,
  // configuration transaction
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [0:0]                   cfg_index,
  input  logic        [smon_pkg::PID_W-1:0]   cfg_data,
  // result
  output logic                                result_valid,
  output logic        [smon_pkg::VERD_W-1:0]  verdict,
  output logic        [smon_pkg::STATE_W-1:0] new_state
);

  import smon_pkg::*;

  localparam int TSIZE = NUM_STATES * NUM_STATES;
  localparam int AW    = $clog2(TSIZE);

  logic [PID_W-1:0]          watched_pid;
  logic [STATE_W-1:0]        dead_state;
  logic                      ram_we;
  logic [AW-1:0]             ram_addr;
  logic signed [ENTRY_W-1:0] ram_wdata, ram_rdata;

  // Registers may be written at any time; the user must issue writes only while idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      watched_pid <= '0;
      dead_state  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WATCHED_PID: watched_pid <= cfg_data;
        CFG_DEAD_STATE:  dead_state  <= cfg_data[STATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Transition table, row-major: entry row*N + col.
  smon_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TSIZE)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_addr),
    .wr_data (ram_wdata),
    .rd_addr (ram_addr),
    .rd_data (ram_rdata)
  );

  // Sequencer: walks the current row, dives into epsilon target rows,
  // and resolves the verdict with the shared entry comparator.
  smon_ctrl #(
    .NUM_STATES (NUM_STATES),
    .AW         (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .pid          (pid),
    .syscall_id   (syscall_id),
    .entry_index  (entry_index),
    .entry_value  (entry_value),
    .watched_pid  (watched_pid),
    .dead_state   (dead_state),
    .ram_we       (ram_we),
    .ram_addr     (ram_addr),
    .ram_wdata    (ram_wdata),
    .ram_rdata    (ram_rdata),
    .result_valid (result_valid),
    .verdict      (verdict),
    .new_state    (new_state)
  );

endmodule
